// ===== sv/mme_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types and constants for the matrix multiply engine: request and
// register codes, field widths, controller-to-datapath command and status.
// ----------------------------------------------------------------------------
package mme_pkg;

  // Field widths fixed by the transaction format
  localparam int REQ_W   = 2;
  localparam int IDX_W   = 3;
  localparam int CNT_W   = 4;
  localparam int ELEM_W  = 32;
  localparam int CFG_A_W = 2;

  // Default configuration of the engine
  localparam int MAX_DIM_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;

  // Reset value of every size register
  localparam logic [CNT_W-1:0] SIZE_RESET = 4'd8;

  // Request codes of the input channel
  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_START  = 2'd2
  } req_t;

  // Configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    CFG_A_ROWS = 2'd0,
    CFG_A_COLS = 2'd1,
    CFG_B_ROWS = 2'd2,
    CFG_B_COLS = 2'd3
  } cfg_reg_t;

  // Controller -> datapath command
  typedef struct packed {
    logic             wr_a;      // write A store at input row/col
    logic             wr_b;      // write B store at input row/col
    logic             rd;        // issue one multiply-accumulate step
    logic             k_first;   // first term of a dot product
    logic             k_last;    // last term of a dot product
    logic             err_set;   // load a dimension-error result
    logic             elem_last; // current element is the last of the run
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] k;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic moved;     // finished result went to the output register
    logic hold_full; // finished result waiting in the accumulator
  } stat_t;

endpackage
`default_nettype wire

// ===== sv/mme_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mme_in_if
// Input channel: load and start requests with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mme_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  row_index;
  logic [2:0]  col_index;
  logic [31:0] element_value;

  modport source (output valid, req_type, row_index, col_index, element_value,
                  input ready);
  modport sink   (input valid, req_type, row_index, col_index, element_value,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/mme_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mme_out_if
// Result channel: one product element per transaction.
// ----------------------------------------------------------------------------
interface mme_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_row;
  logic [2:0]  out_col;
  logic [31:0] product_value;
  logic        dims_error;
  logic        last_flag;

  modport source (output valid, out_row, out_col, product_value, dims_error,
                  last_flag, input ready);
  modport sink   (input valid, out_row, out_col, product_value, dims_error,
                  last_flag, output ready);
endinterface
`default_nettype wire

// ===== sv/mme_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mme_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mme_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [3:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

// ===== sv/matrix_multiply_engine.sv =====
`default_nettype none
// Timing: a load is written to its store when accepted; a start on R x K by K x C
//   matrices issues one multiply-accumulate step per term on the single multiplier,
//   then store read, multiply and accumulate; a size mismatch sets an error result.
//   A finished result leaves the accumulator once the output register is free; the
//   next is issued only then; new requests wait until the last one of a run has left.
// Reset: synchronous, active low; clears control, size registers to 8; the
//   element stores are not cleared.
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// General matrix multiply on signed Q16.16 elements: controller plus datapath.
// ----------------------------------------------------------------------------
module matrix_multiply_engine #(
  parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mme_pkg::FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mme_in_if.sink     in_ch,
  mme_out_if.source  out_ch,
  mme_cfg_if.sink    cfg_ch
);
  import mme_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mme_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_req_type (in_ch.req_type),
    .in_row      (in_ch.row_index),
    .in_col      (in_ch.col_index),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_index   (cfg_ch.reg_index),
    .cfg_data    (cfg_ch.wr_data),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  mme_datapath #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_row    (in_ch.row_index),
    .in_col    (in_ch.col_index),
    .in_value  (in_ch.element_value),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_row   (out_ch.out_row),
    .out_col   (out_ch.out_col),
    .out_value (out_ch.product_value),
    .out_err   (out_ch.dims_error),
    .out_last  (out_ch.last_flag)
  );

endmodule
`default_nettype wire

// ===== sv/mme_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mme_ctrl
// Controller: size registers, request decode and the i/j/k loop sequencer
// that drives the datapath one multiply-accumulate step per cycle when issuing.
// ----------------------------------------------------------------------------
module mme_ctrl #(
  parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input channel handshake and decode fields
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [mme_pkg::REQ_W-1:0]  in_req_type,
  input  wire logic [mme_pkg::IDX_W-1:0]  in_row,
  input  wire logic [mme_pkg::IDX_W-1:0]  in_col,
  // configuration channel
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [mme_pkg::CFG_A_W-1:0] cfg_index,
  input  wire logic [mme_pkg::CNT_W-1:0]  cfg_data,
  // datapath
  output mme_pkg::cmd_t                   cmd_o,
  input  wire mme_pkg::stat_t             stat_i
);
  import mme_pkg::*;

  localparam logic [CNT_W-1:0] DIM_L = CNT_W'(MAX_DIM);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic             err_r, err_nxt;
  logic [CNT_W-1:0] r1, c1, r2, c2;
  logic             in_fire, cfg_fire;
  logic             is_load_a, is_load_b, is_start;
  logic             k_last, elem_last;

  // Out-of-range sizes: zero acts as one, above the maximum acts as the maximum
  function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] v);
    if (v == '0)
      return CNT_W'(1);
    if (v > DIM_L)
      return DIM_L;
    return v;
  endfunction

  assign r1 = eff_size(a_rows_r);
  assign c1 = eff_size(a_cols_r);
  assign r2 = eff_size(b_rows_r);
  assign c2 = eff_size(b_cols_r);

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid & in_ready;
  assign cfg_fire  = cfg_valid & cfg_ready;

  // Request decode
  assign is_load_a = in_fire && (in_req_type == REQ_LOAD_A);
  assign is_load_b = in_fire && (in_req_type == REQ_LOAD_B);
  assign is_start  = in_fire && (in_req_type == REQ_START);

  // Loop end conditions
  assign k_last    = ({1'b0, k_r} + CNT_W'(1)) == c1;
  assign elem_last = (({1'b0, i_r} + CNT_W'(1)) == r1) &&
                     (({1'b0, j_r} + CNT_W'(1)) == c2);

  // Commands to the datapath
  always_comb begin
    cmd_o           = '0;
    cmd_o.wr_a      = is_load_a && ({1'b0, in_row} < r1) && ({1'b0, in_col} < c1);
    cmd_o.wr_b      = is_load_b && ({1'b0, in_row} < r2) && ({1'b0, in_col} < c2);
    cmd_o.rd        = (state_r == ST_ISSUE);
    cmd_o.k_first   = (k_r == '0);
    cmd_o.k_last    = k_last;
    cmd_o.err_set   = is_start && (c1 != r2);
    cmd_o.elem_last = elem_last;
    cmd_o.row       = i_r;
    cmd_o.col       = j_r;
    cmd_o.k         = k_r;
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    err_nxt   = err_r;
    case (state_r)
      ST_IDLE: begin
        if (is_start) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          err_nxt   = (c1 != r2);
          state_nxt = (c1 != r2) ? ST_DRAIN : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (stat_i.moved) begin
          k_nxt = '0;
          if (err_r || elem_last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_ISSUE;
            if (({1'b0, j_r} + CNT_W'(1)) == c2) begin
              j_nxt = '0;
              i_nxt = i_r + IDX_W'(1);
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, loop counters and size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      err_r    <= 1'b0;
      a_rows_r <= SIZE_RESET;
      a_cols_r <= SIZE_RESET;
      b_rows_r <= SIZE_RESET;
      b_cols_r <= SIZE_RESET;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      err_r   <= err_nxt;
      if (cfg_fire) begin
        case (cfg_index)
          CFG_A_ROWS: a_rows_r <= cfg_data;
          CFG_A_COLS: a_cols_r <= cfg_data;
          CFG_B_ROWS: b_rows_r <= cfg_data;
          CFG_B_COLS: b_cols_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTH
  // A result only moves out of the accumulator while we wait for it
  a_moved_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    stat_i.moved |-> (state_r == ST_DRAIN))
    else $error("result moved outside drain state");

  // No new dot product starts while a finished one still sits in the accumulator
  a_issue_hold_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ISSUE) |-> !stat_i.hold_full)
    else $error("issue while accumulator holds a result");

  // The k loop stays within A's column count
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.rd |-> ({1'b0, k_r} < c1))
    else $error("k index out of range");
`endif

endmodule
`default_nettype wire

// ===== sv/mme_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mme_datapath
// Datapath: A and B element stores, registered read, 32x32 multiplier,
// wide accumulator, shift/saturate and the result output register.
// ----------------------------------------------------------------------------
module mme_datapath #(
  parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mme_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // load payload
  input  wire logic [mme_pkg::IDX_W-1:0]   in_row,
  input  wire logic [mme_pkg::IDX_W-1:0]   in_col,
  input  wire logic [mme_pkg::ELEM_W-1:0]  in_value,
  // controller
  input  wire mme_pkg::cmd_t               cmd_i,
  output mme_pkg::stat_t                   stat_o,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [mme_pkg::IDX_W-1:0]        out_row,
  output logic [mme_pkg::IDX_W-1:0]        out_col,
  output logic [mme_pkg::ELEM_W-1:0]       out_value,
  output logic                             out_err,
  output logic                             out_last
);
  import mme_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // 64-bit products, summed over up to MAX_DIM terms, plus a sign bit
  localparam int ACC_W = 2 * ELEM_W + ((MAX_DIM > 1) ? $clog2(MAX_DIM) : 0) + 1;

  logic [ELEM_W-1:0]        mem_a [DEPTH];
  logic [ELEM_W-1:0]        mem_b [DEPTH];
  logic [AW-1:0]            wr_addr, rd_a_addr, rd_b_addr;
  logic signed [ELEM_W-1:0] a_q_r, b_q_r;
  logic signed [2*ELEM_W-1:0] mul_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  shifted;
  logic [ELEM_W-1:0]        sat_val;
  logic                     v1_r, first1_r, last1_r;
  logic                     v2_r, first2_r, last2_r;
  logic                     hold_full_r, hold_err_r;
  logic                     move;
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic [ELEM_W-1:0]        out_value_r;
  logic                     out_err_r, out_last_r;

  // Row-major store address
  function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                            input logic [IDX_W-1:0] c);
    return AW'(r) * AW'(MAX_DIM) + AW'(c);
  endfunction

  assign wr_addr   = addr_of(in_row, in_col);
  assign rd_a_addr = addr_of(cmd_i.row, cmd_i.k);
  assign rd_b_addr = addr_of(cmd_i.k, cmd_i.col);

  // Element stores: one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd_i.wr_a)
      mem_a[wr_addr] <= in_value;
    if (cmd_i.wr_b)
      mem_b[wr_addr] <= in_value;
    a_q_r <= mem_a[rd_a_addr];
    b_q_r <= mem_b[rd_b_addr];
  end

  // Multiplier stage
  always_ff @(posedge clk) begin
    mul_r <= a_q_r * b_q_r;
  end

  // Shift out the fraction bits and saturate to 32 bits
  assign shifted = acc_r >>> FRAC_BITS;
  always_comb begin
    if ((&shifted[ACC_W-1:ELEM_W-1]) || !(|shifted[ACC_W-1:ELEM_W-1]))
      sat_val = shifted[ELEM_W-1:0];
    else if (shifted[ACC_W-1])
      sat_val = {1'b1, {(ELEM_W-1){1'b0}}};
    else
      sat_val = {1'b0, {(ELEM_W-1){1'b1}}};
  end

  // Finished result moves to the output register when that is free
  assign move          = hold_full_r && (!out_valid_r || out_ready);
  assign stat_o.moved     = move;
  assign stat_o.hold_full = hold_full_r;

  // Accumulator
  always_ff @(posedge clk) begin
    if (v2_r) begin
      if (first2_r)
        acc_r <= ACC_W'(mul_r);
      else
        acc_r <= acc_r + ACC_W'(mul_r);
    end
  end

  // Step flags through read and multiply, hold flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      first1_r    <= 1'b0;
      last1_r     <= 1'b0;
      v2_r        <= 1'b0;
      first2_r    <= 1'b0;
      last2_r     <= 1'b0;
      hold_full_r <= 1'b0;
      hold_err_r  <= 1'b0;
    end else begin
      v1_r     <= cmd_i.rd;
      first1_r <= cmd_i.k_first;
      last1_r  <= cmd_i.k_last;
      v2_r     <= v1_r;
      first2_r <= first1_r;
      last2_r  <= last1_r;
      if (cmd_i.err_set) begin
        hold_full_r <= 1'b1;
        hold_err_r  <= 1'b1;
      end else if (v2_r && last2_r) begin
        hold_full_r <= 1'b1;
        hold_err_r  <= 1'b0;
      end else if (move) begin
        hold_full_r <= 1'b0;
      end
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (move) begin
      out_row_r   <= hold_err_r ? '0 : cmd_i.row;
      out_col_r   <= hold_err_r ? '0 : cmd_i.col;
      out_value_r <= hold_err_r ? '0 : sat_val;
      out_err_r   <= hold_err_r;
      out_last_r  <= hold_err_r | cmd_i.elem_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_err   = out_err_r;
  assign out_last  = out_last_r;

`ifndef SYNTH
  // A dot product never completes over a result still waiting to move
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && last2_r) |-> !hold_full_r)
    else $error("accumulator overwritten before result moved");

  // An error result is always the final one of its run
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> out_last_r)
    else $error("error result without last flag");

  // An error result is raised only with no products in flight
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.err_set |-> (!v1_r && !v2_r && !hold_full_r))
    else $error("error result raised while pipeline busy");
`endif

endmodule
`default_nettype wire
